[design/wavhp_pkg.sv]
// Package for the RIFF/WAVE header parser: payload types, phase codes, status codes.
package wavhp_pkg;

	// Input transfer payload
	typedef struct packed {
		logic [7:0] byte_value;
		logic       first_byte;
		logic       stream_end;
	} wavhp_in_t;

	// Result transfer payload
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] data_len;
		logic [32:0] data_offset;
	} wavhp_out_t;

	// Parse phase of the current file
	typedef enum logic [2:0] {
		PH_RIFF,
		PH_HDR,
		PH_SKIP,
		PH_FMT,
		PH_DONE
	} wavhp_phase_t;

	// Sequencer for the shared multiplier check
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_MUL_BLK,
		SEQ_MUL_PROD,
		SEQ_DECIDE
	} wavhp_seq_t;

	// Verdict codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EARLY    = 3'd1;
	localparam logic [2:0] ST_NOT_WAVE = 3'd2;
	localparam logic [2:0] ST_FMT_SIZE = 3'd3;
	localparam logic [2:0] ST_RATES    = 3'd4;
	localparam logic [2:0] ST_FORMAT   = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_CHANNELS    = 2'd0;
	localparam logic [1:0] CFG_SAMPLE_RATE = 2'd1;
	localparam logic [1:0] CFG_BITS        = 2'd2;

	// Chunk identifiers as little-endian words
	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
	localparam logic [15:0] FMT_PCM        = 16'd1;

endpackage

[design/wav_header_parser_top.sv]
// RIFF/WAVE header parser: byte-stream header checker with a shared multiplier check.
//
//  channel   dir  handshake                     payload
//  byte      in   byte_valid / byte_stall       byte_item   (wavhp_in_t)
//  result    out  result_valid / result_stall   result_item (wavhp_out_t)
//  cfg       in   cfg_write                     cfg_index, cfg_data
//
// Bytes are taken while byte_stall is low. The last byte of the fmt body starts a check on
// one shared 32x32 multiplier (channels*bits, then rate*that, then compare), and byte_stall
// stays high from that byte until the check is decided.
// Reset clears the parse as if a new file had started; config takes its defaults.
// byte_stall is also high while a finished result waits under result_stall.
module wav_header_parser_top
	import wavhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  wavhp_in_t   byte_item,
	output logic        result_valid,
	input  logic        result_stall,
	output wavhp_out_t  result_item,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Configuration registers
	logic [15:0] exp_channels_q;
	logic [31:0] exp_rate_q;
	logic [15:0] exp_bits_q;

	// Parse state
	wavhp_phase_t phase_q, phase_d;
	logic [3:0]   bc_q, bc_d;
	logic         riff_bad_q, riff_bad_d;
	logic         seeking_q, seeking_d;
	logic [32:0]  pos_q, pos_d;
	logic [32:0]  skip_q, skip_d;
	logic [31:0]  chunk_id_q, chunk_id_d;
	logic [31:0]  chunk_size_q, chunk_size_d;
	logic [15:0]  fmt_format_q, fmt_format_d;
	logic [15:0]  fmt_channels_q, fmt_channels_d;
	logic [31:0]  fmt_rate_q, fmt_rate_d;
	logic [31:0]  fmt_byte_rate_q, fmt_byte_rate_d;
	logic [15:0]  fmt_align_q, fmt_align_d;
	logic [15:0]  fmt_bits_q, fmt_bits_d;

	// Check sequencer and shared multiplier
	wavhp_seq_t  seq_q, seq_d;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_full;
	logic [31:0] blk_q, prod_q;
	logic        busy, decide_go, fmt_done;

	// Output register
	logic        out_valid_q;
	wavhp_out_t  out_q;
	logic        emit;
	wavhp_out_t  emit_item;

	logic byte_fire;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_channels_q <= 16'd1;
			exp_rate_q     <= 32'd44100;
			exp_bits_q     <= 16'd16;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_CHANNELS:    exp_channels_q <= cfg_data[15:0];
				CFG_SAMPLE_RATE: exp_rate_q     <= cfg_data;
				CFG_BITS:        exp_bits_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sequencer outputs: stall, multiplier operands, decide strobe
	always_comb begin
		busy      = (seq_q != SEQ_IDLE);
		decide_go = (seq_q == SEQ_DECIDE) && !(out_valid_q && result_stall);
		case (seq_q)
			SEQ_MUL_BLK: begin
				mul_a = {16'd0, fmt_channels_q};
				mul_b = {16'd0, fmt_bits_q};
			end
			SEQ_MUL_PROD: begin
				mul_a = fmt_rate_q;
				mul_b = blk_q;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign mul_full   = mul_a * mul_b;
	assign byte_stall = busy || (out_valid_q && result_stall);
	assign byte_fire  = byte_valid && !byte_stall;

	// Sequencer next state
	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			SEQ_IDLE:     if (fmt_done) seq_d = SEQ_MUL_BLK;
			SEQ_MUL_BLK:  seq_d = SEQ_MUL_PROD;
			SEQ_MUL_PROD: seq_d = SEQ_DECIDE;
			SEQ_DECIDE:   if (decide_go) seq_d = SEQ_IDLE;
			default:      seq_d = SEQ_IDLE;
		endcase
	end

	// Byte processing and verdict logic
	always_comb begin
		wavhp_phase_t ph;
		logic [3:0]   k;
		logic [7:0]   b;
		logic [31:0]  size_full;
		logic [32:0]  skip_new;

		phase_d         = phase_q;
		bc_d            = bc_q;
		riff_bad_d      = riff_bad_q;
		seeking_d       = seeking_q;
		pos_d           = pos_q;
		skip_d          = skip_q;
		chunk_id_d      = chunk_id_q;
		chunk_size_d    = chunk_size_q;
		fmt_format_d    = fmt_format_q;
		fmt_channels_d  = fmt_channels_q;
		fmt_rate_d      = fmt_rate_q;
		fmt_byte_rate_d = fmt_byte_rate_q;
		fmt_align_d     = fmt_align_q;
		fmt_bits_d      = fmt_bits_q;
		emit            = 1'b0;
		emit_item       = '{status: ST_OK, data_len: 32'd0, data_offset: 33'd0};
		fmt_done        = 1'b0;
		b               = byte_item.byte_value;
		size_full       = {b, chunk_size_q[23:0]};
		skip_new        = 33'd0;

		// restart on first byte
		if (byte_fire && byte_item.first_byte) begin
			phase_d    = PH_RIFF;
			bc_d       = 4'd0;
			riff_bad_d = 1'b0;
			seeking_d  = 1'b0;
			pos_d      = 33'd0;
			skip_d     = 33'd0;
		end
		ph = phase_d;
		k  = bc_d;

		if (byte_fire && ph != PH_DONE) begin
			if (byte_item.stream_end) begin
				emit      = 1'b1;
				emit_item.status = ST_EARLY;
				phase_d   = PH_DONE;
			end else begin
				pos_d = pos_d + 33'd1;
				case (ph)
					PH_RIFF: begin
						if (k < 4'd4 && b != ID_RIFF[8*k[1:0] +: 8])
							riff_bad_d = 1'b1;
						if (k >= 4'd8 && b != ID_WAVE[8*k[1:0] +: 8])
							riff_bad_d = 1'b1;
						bc_d = k + 4'd1;
						if (k == 4'd11) begin
							bc_d = 4'd0;
							if (riff_bad_d) begin
								emit             = 1'b1;
								emit_item.status = ST_NOT_WAVE;
								phase_d          = PH_DONE;
							end else begin
								phase_d = PH_HDR;
							end
						end
					end
					PH_SKIP: begin
						skip_d = skip_q - 33'd1;
						if (skip_d == 33'd0) begin
							phase_d = PH_HDR;
							bc_d    = 4'd0;
						end
					end
					PH_HDR: begin
						if (k < 4'd4) chunk_id_d[8*k[1:0] +: 8] = b;
						else chunk_size_d[8*k[1:0] +: 8] = b;
						bc_d = k + 4'd1;
						if (k == 4'd7) begin
							bc_d = 4'd0;
							skip_new = {1'b0, size_full} + {32'd0, size_full[0]};
							if (!seeking_q && chunk_id_q == ID_FMT) begin
								if (size_full != FMT_CHUNK_SIZE) begin
									emit             = 1'b1;
									emit_item.status = ST_FMT_SIZE;
									phase_d          = PH_DONE;
								end else begin
									phase_d = PH_FMT;
								end
							end else if (seeking_q && chunk_id_q == ID_DATA) begin
								emit                  = 1'b1;
								emit_item.data_len    = size_full;
								emit_item.data_offset = pos_d;
								phase_d               = PH_DONE;
							end else begin
								skip_d  = skip_new;
								phase_d = (skip_new == 33'd0) ? PH_HDR : PH_SKIP;
							end
						end
					end
					PH_FMT: begin
						case (k)
							4'd0, 4'd1:   fmt_format_d[8*k[0] +: 8] = b;
							4'd2, 4'd3:   fmt_channels_d[8*k[0] +: 8] = b;
							4'd4, 4'd5, 4'd6, 4'd7:
								fmt_rate_d[8*k[1:0] +: 8] = b;
							4'd8, 4'd9, 4'd10, 4'd11:
								fmt_byte_rate_d[8*k[1:0] +: 8] = b;
							4'd12, 4'd13: fmt_align_d[8*k[0] +: 8] = b;
							default:      fmt_bits_d[8*k[0] +: 8] = b;
						endcase
						bc_d = k + 4'd1;
						// last body byte hands over to the multiplier check
						if (k == 4'd15) fmt_done = 1'b1;
					end
					default: ;
				endcase
			end
		end else if (decide_go) begin
			// verdict order: consistency, then format and config
			if (fmt_byte_rate_q != {3'd0, prod_q[31:3]} ||
			    {16'd0, fmt_align_q} != {3'd0, blk_q[31:3]}) begin
				emit             = 1'b1;
				emit_item.status = ST_RATES;
				phase_d          = PH_DONE;
			end else if (fmt_format_q != FMT_PCM || fmt_channels_q != exp_channels_q ||
			             fmt_rate_q != exp_rate_q || fmt_bits_q != exp_bits_q) begin
				emit             = 1'b1;
				emit_item.status = ST_FORMAT;
				phase_d          = PH_DONE;
			end else begin
				seeking_d = 1'b1;
				phase_d   = PH_HDR;
				bc_d      = 4'd0;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RIFF;
			bc_q        <= 4'd0;
			riff_bad_q  <= 1'b0;
			seeking_q   <= 1'b0;
			pos_q       <= 33'd0;
			skip_q      <= 33'd0;
			seq_q       <= SEQ_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			bc_q       <= bc_d;
			riff_bad_q <= riff_bad_d;
			seeking_q  <= seeking_d;
			pos_q      <= pos_d;
			skip_q     <= skip_d;
			seq_q      <= seq_d;
			if (emit) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		chunk_id_q      <= chunk_id_d;
		chunk_size_q    <= chunk_size_d;
		fmt_format_q    <= fmt_format_d;
		fmt_channels_q  <= fmt_channels_d;
		fmt_rate_q      <= fmt_rate_d;
		fmt_byte_rate_q <= fmt_byte_rate_d;
		fmt_align_q     <= fmt_align_d;
		fmt_bits_q      <= fmt_bits_d;
		if (seq_q == SEQ_MUL_BLK) blk_q <= mul_full[31:0];
		if (seq_q == SEQ_MUL_PROD) prod_q <= mul_full[31:0];
		if (emit) out_q <= emit_item;
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

endmodule

[tb/testbench.sv]
// Testbench for wav_header_parser_top: directed table, random files, inline predictor.
`timescale 1ns / 1ps

module testbench;
	import wavhp_pkg::*;

	localparam int unsigned ITEMS     = 1800;
	localparam int unsigned HOLD_LEN  = 400;
	localparam int unsigned SETTLE    = 8;
	localparam int unsigned QUIET_MAX = 5000;

	// One offered byte transfer, with an optional hand-typed verdict
	typedef struct packed {
		wavhp_in_t  item;
		logic       typed;
		wavhp_out_t want;
	} byte_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	wavhp_in_t   byte_item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	wavhp_out_t  result_item;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = CFG_CHANNELS;
	logic [31:0] cfg_data = '0;

	wav_header_parser_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #1 clk = ~clk;

	// Header parse state mirrored by the predictor
	wavhp_phase_t hdr_phase;
	logic [4:0]   idx_in_field;
	logic [31:0]  cur_id;
	logic [31:0]  cur_len;
	logic [32:0]  skip_left;
	logic         after_fmt;
	logic [32:0]  file_pos;
	logic         riff_mismatch;
	logic [15:0]  wf_format, wf_channels, wf_align, wf_bits;
	logic [31:0]  wf_rate, wf_byte_rate;

	// Register copies
	logic [15:0] need_channels = 16'd1;
	logic [31:0] need_rate = 32'd44100;
	logic [15:0] need_bits = 16'd16;

	wavhp_out_t  verdict_q[$];
	byte_row_t   offered_q[$];
	wavhp_in_t   file_q[$];

	int unsigned mismatches = 0;
	int unsigned bytes_parsed = 0;
	int unsigned verdicts_seen = 0;
	int unsigned status_tally[6] = '{default: 0};
	int unsigned settings_used = 1;
	int unsigned sender_calm = 0;
	int unsigned quiet_cycles = 0;
	bit          hold_req = 1'b0;
	bit          next_first = 1'b0;

	function automatic bit chance(input int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic void new_file();
		hdr_phase     = PH_RIFF;
		idx_in_field  = '0;
		cur_id        = '0;
		cur_len       = '0;
		skip_left     = '0;
		after_fmt     = 1'b0;
		file_pos      = '0;
		riff_mismatch = 1'b0;
		wf_format     = '0;
		wf_channels   = '0;
		wf_rate       = '0;
		wf_byte_rate  = '0;
		wf_align      = '0;
		wf_bits       = '0;
	endfunction

	function automatic wavhp_out_t close_file(input logic [2:0] st, input logic [31:0] len,
			input logic [32:0] off);
		wavhp_out_t r;
		r.status      = st;
		r.data_len    = len;
		r.data_offset = off;
		hdr_phase     = PH_DONE;
		return r;
	endfunction

	// Predictor: advance the parse by one byte transfer, maybe yielding a verdict
	task automatic parse_byte(input wavhp_in_t it, output bit got, output wavhp_out_t res,
			output bit used);
		logic [7:0]  b;
		logic [4:0]  k;
		logic [31:0] blk;
		logic [63:0] wide;
		b    = it.byte_value;
		got  = 1'b0;
		res  = '0;
		used = 1'b0;
		if (it.first_byte) new_file();
		if (hdr_phase == PH_DONE) return;
		used = 1'b1;
		if (it.stream_end) begin
			res = close_file(ST_EARLY, '0, '0);
			got = 1'b1;
			return;
		end
		file_pos = file_pos + 33'd1;
		k = idx_in_field;
		case (hdr_phase)
			PH_RIFF: begin
				if (k < 4 && b != 8'(ID_RIFF >> (8 * k[1:0]))) riff_mismatch = 1'b1;
				if (k >= 8 && k < 12 && b != 8'(ID_WAVE >> (8 * k[1:0]))) riff_mismatch = 1'b1;
				idx_in_field = k + 5'd1;
				if (idx_in_field == 5'd12) begin
					if (riff_mismatch) begin
						res = close_file(ST_NOT_WAVE, '0, '0);
						got = 1'b1;
					end else begin
						hdr_phase = PH_HDR;
						idx_in_field = '0;
					end
				end
			end
			PH_SKIP: begin
				if (skip_left != 0) skip_left = skip_left - 33'd1;
				if (skip_left == 0) begin
					hdr_phase = PH_HDR;
					idx_in_field = '0;
				end
			end
			PH_HDR: begin
				if (k < 4) begin
					if (k == 0) cur_id = '0;
					cur_id = cur_id | (32'(b) << (8 * k[1:0]));
				end else begin
					if (k == 4) cur_len = '0;
					cur_len = cur_len | (32'(b) << (8 * k[1:0]));
				end
				idx_in_field = k + 5'd1;
				if (idx_in_field == 5'd8) begin
					idx_in_field = '0;
					if (!after_fmt && cur_id == ID_FMT) begin
						if (cur_len != FMT_CHUNK_SIZE) begin
							res = close_file(ST_FMT_SIZE, '0, '0);
							got = 1'b1;
						end else begin
							hdr_phase = PH_FMT;
						end
					end else if (after_fmt && cur_id == ID_DATA) begin
						res = close_file(ST_OK, cur_len, file_pos);
						got = 1'b1;
					end else begin
						// unwanted chunk: body plus pad byte when odd
						skip_left = {1'b0, cur_len} + 33'(cur_len[0]);
						hdr_phase = (skip_left == 0) ? PH_HDR : PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				if (k < 2)       wf_format    = wf_format    | (16'(b) << (8 * k[0]));
				else if (k < 4)  wf_channels  = wf_channels  | (16'(b) << (8 * k[0]));
				else if (k < 8)  wf_rate      = wf_rate      | (32'(b) << (8 * k[1:0]));
				else if (k < 12) wf_byte_rate = wf_byte_rate | (32'(b) << (8 * k[1:0]));
				else if (k < 14) wf_align     = wf_align     | (16'(b) << (8 * k[0]));
				else             wf_bits      = wf_bits      | (16'(b) << (8 * k[0]));
				idx_in_field = k + 5'd1;
				if (idx_in_field == 5'd16) begin
					idx_in_field = '0;
					blk  = {16'b0, wf_channels} * {16'b0, wf_bits};
					wide = {32'b0, wf_rate} * {32'b0, blk};
					if (wf_byte_rate != (wide[31:0] >> 3) || {16'b0, wf_align} != (blk >> 3)) begin
						res = close_file(ST_RATES, '0, '0);
						got = 1'b1;
					end else if (wf_format != FMT_PCM || wf_channels != need_channels ||
							wf_rate != need_rate || wf_bits != need_bits) begin
						res = close_file(ST_FORMAT, '0, '0);
						got = 1'b1;
					end else begin
						after_fmt = 1'b1;
						hdr_phase = PH_HDR;
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic byte_row_t row(input logic [7:0] b, input bit starts, input bit at_end,
			input bit typed, input logic [2:0] st);
		byte_row_t r;
		r = '0;
		r.item.byte_value = b;
		r.item.first_byte = starts;
		r.item.stream_end = at_end;
		r.typed = typed;
		r.want.status = st;
		return r;
	endfunction

	// Sender gaps: mostly none or short, a few long, with calm stretches
	function automatic int unsigned byte_gap();
		int unsigned r;
		if (sender_calm != 0) begin
			sender_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			sender_calm = $urandom_range(40, 200);
			return 0;
		end
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one byte transfer and wait until it is taken
	task automatic offer(input byte_row_t r);
		int unsigned gap;
		gap = byte_gap();
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		offered_q.push_back(r);
		byte_valid <= 1'b1;
		byte_item  <= r.item;
		do @(posedge clk); while (byte_stall);
	endtask

	// Stop offering and wait until every verdict is in and the multiplier check is done
	task automatic drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Upper bits of the 16-bit registers carry junk that must be dropped
	task automatic write_config(input logic [15:0] ch, input logic [31:0] rate,
			input logic [15:0] bits);
		cfg_write <= 1'b1;
		cfg_index <= CFG_CHANNELS;
		cfg_data  <= {16'($urandom), ch};
		@(posedge clk);
		need_channels = ch;
		cfg_index <= CFG_SAMPLE_RATE;
		cfg_data  <= rate;
		@(posedge clk);
		need_rate = rate;
		cfg_index <= CFG_BITS;
		cfg_data  <= {16'($urandom), bits};
		@(posedge clk);
		need_bits = bits;
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	task automatic add_byte(input logic [7:0] b, input bit at_end);
		wavhp_in_t it;
		it.byte_value = b;
		it.first_byte = next_first;
		it.stream_end = at_end;
		next_first = 1'b0;
		file_q.push_back(it);
	endtask

	task automatic add_word(input logic [31:0] w, input int unsigned n);
		for (int unsigned i = 0; i < n; i++) add_byte(8'(w >> (8 * i)), 1'b0);
	endtask

	// Unwanted chunk; a huge one is cut short and closes the file
	task automatic add_junk(input bit past_fmt, output bit ended);
		logic [31:0] id, len;
		ended = 1'b0;
		if (!past_fmt) begin
			id = chance(30) ? ID_DATA : $urandom;
			if (id == ID_FMT) id = id ^ 32'd1;
		end else begin
			id = chance(30) ? ID_FMT : $urandom;
			if (id == ID_DATA) id = id ^ 32'd1;
		end
		len = chance(90) ? $urandom_range(0, 9) : ($urandom | 32'h0100_0000);
		add_word(id, 4);
		add_word(len, 4);
		if (len > 32'd9) begin
			repeat ($urandom_range(0, 5)) add_byte(8'($urandom), 1'b0);
			if (chance(50)) add_byte(8'($urandom), 1'b1);
			ended = 1'b1;
		end else begin
			repeat (len + len[0]) add_byte(8'($urandom), 1'b0);
		end
	endtask

	// Build one random file into file_q
	task automatic make_file();
		int unsigned kind, pick, cut;
		bit          ended;
		logic [31:0] riff, wave, len, rate, brate, blk;
		logic [15:0] fmt, ch, bits, align;
		logic [63:0] wide;
		file_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 30)) begin
				next_first = chance(10);
				add_byte(8'($urandom), chance(6));
			end
			return;
		end
		if (kind < 11) begin
			next_first = 1'b1;
			add_byte(8'($urandom), 1'b1);
			return;
		end
		riff = ID_RIFF;
		wave = ID_WAVE;
		if (chance(6)) begin
			pick = $urandom_range(0, 7);
			if (pick < 4) riff = riff ^ (32'($urandom_range(1, 255)) << (8 * pick));
			else          wave = wave ^ (32'($urandom_range(1, 255)) << (8 * (pick - 4)));
		end
		next_first = !chance(3);
		add_word(riff, 4);
		add_word($urandom, 4);
		add_word(wave, 4);
		repeat ($urandom_range(0, 2)) begin
			add_junk(1'b0, ended);
			if (ended) return;
		end
		// fmt chunk header
		add_word(ID_FMT, 4);
		if (chance(7)) begin
			pick = $urandom_range(0, 3);
			case (pick)
				0: len = 32'd0;
				1: len = 32'hFFFF_FFFF;
				2: len = 32'd18;
				default: len = $urandom_range(17, 1000);
			endcase
			add_word(len, 4);
			repeat (2) add_byte(8'($urandom), 1'b0);
			return;
		end
		add_word(FMT_CHUNK_SIZE, 4);
		// fmt body, mostly consistent and matching the registers
		fmt  = chance(90) ? FMT_PCM : 16'($urandom);
		ch   = chance(85) ? need_channels : 16'($urandom);
		rate = chance(85) ? need_rate : $urandom;
		bits = chance(85) ? need_bits : 16'($urandom);
		blk   = {16'b0, ch} * {16'b0, bits};
		wide  = {32'b0, rate} * {32'b0, blk};
		brate = wide[31:0] >> 3;
		align = 16'(blk >> 3);
		if (chance(8)) brate = brate ^ (32'd1 << $urandom_range(0, 31));
		if (chance(8)) align = align ^ (16'd1 << $urandom_range(0, 15));
		add_word({16'b0, fmt}, 2);
		add_word({16'b0, ch}, 2);
		add_word(rate, 4);
		add_word(brate, 4);
		add_word({16'b0, align}, 2);
		add_word({16'b0, bits}, 2);
		repeat ($urandom_range(0, 2)) begin
			add_junk(1'b1, ended);
			if (ended) return;
		end
		// data chunk header
		add_word(ID_DATA, 4);
		pick = $urandom_range(0, 3);
		case (pick)
			0: len = 32'd0;
			1: len = 32'hFFFF_FFFF;
			2: len = $urandom_range(1, 4096);
			default: len = $urandom;
		endcase
		add_word(len, 4);
		repeat ($urandom_range(0, 3)) add_byte(8'($urandom), 1'b0);
		// early end somewhere in the file
		if (chance(15)) begin
			cut = $urandom_range(1, file_q.size() - 1);
			while (file_q.size() > cut) void'(file_q.pop_back());
			add_byte(8'($urandom), 1'b1);
		end
	endtask

	// Monitor: predict on each byte transfer, check each result transfer
	always @(posedge clk) begin : monitor
		byte_row_t  r;
		wavhp_out_t res, want;
		bit         got, used;
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				r = offered_q.pop_front();
				parse_byte(byte_item, got, res, used);
				if (used) bytes_parsed++;
				if (r.typed) verdict_q.push_back(r.want);
				else if (got) verdict_q.push_back(res);
			end
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					$error("unexpected result transfer: status %0d", result_item.status);
					mismatches++;
				end else begin
					want = verdict_q.pop_front();
					verdicts_seen++;
					if (want.status < 6) status_tally[want.status]++;
					if (result_item.status != want.status) begin
						$error("status: expected %0d, got %0d", want.status, result_item.status);
						mismatches++;
					end
					if (result_item.data_len != want.data_len) begin
						$error("data_len: expected %0h, got %0h", want.data_len,
							result_item.data_len);
						mismatches++;
					end
					if (result_item.data_offset != want.data_offset) begin
						$error("data_offset: expected %0h, got %0h", want.data_offset,
							result_item.data_offset);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == QUIET_MAX) begin
				$display("timeout: %0d cycles without a transfer", QUIET_MAX);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	// Receiver: random stalls, calm stretches, and one long hold-off
	initial begin : receiver
		int unsigned stall_left, calm_left, r;
		stall_left = 0;
		calm_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				result_stall <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (calm_left != 0) begin
				calm_left--;
				result_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3) calm_left = $urandom_range(50, 300);
				else if (r < 23) stall_left = $urandom_range(0, 3);
				else if (r < 25) stall_left = $urandom_range(10, 60);
				result_stall <= (r >= 3 && r < 25);
			end
		end
	end

	initial begin : stimulus
		byte_row_t   directed [22];
		int unsigned files;
		new_file();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: no restart after reset, end, ignored tail, restart with end,
		// bad WAVE tag, and an end right after a restart
		directed = '{
			row("R",   1'b0, 1'b0, 1'b0, ST_OK),
			row("I",   1'b0, 1'b0, 1'b0, ST_OK),
			row("F",   1'b0, 1'b0, 1'b0, ST_OK),
			row("F",   1'b0, 1'b0, 1'b0, ST_OK),
			row(8'hFF, 1'b0, 1'b1, 1'b1, ST_EARLY),
			row(8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
			row(8'hFF, 1'b0, 1'b1, 1'b0, ST_OK),
			row(8'hA5, 1'b1, 1'b1, 1'b1, ST_EARLY),
			row("R",   1'b1, 1'b0, 1'b0, ST_OK),
			row("I",   1'b0, 1'b0, 1'b0, ST_OK),
			row("F",   1'b0, 1'b0, 1'b0, ST_OK),
			row("F",   1'b0, 1'b0, 1'b0, ST_OK),
			row(8'hFF, 1'b0, 1'b0, 1'b0, ST_OK),
			row(8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
			row(8'hFF, 1'b0, 1'b0, 1'b0, ST_OK),
			row(8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
			row("W",   1'b0, 1'b0, 1'b0, ST_OK),
			row("A",   1'b0, 1'b0, 1'b0, ST_OK),
			row("V",   1'b0, 1'b0, 1'b0, ST_OK),
			row("X",   1'b0, 1'b0, 1'b1, ST_NOT_WAVE),
			row(8'h00, 1'b1, 1'b0, 1'b0, ST_OK),
			row(8'h5A, 1'b0, 1'b1, 1'b1, ST_EARLY)
		};
		foreach (directed[i]) offer(directed[i]);

		// Random files over five register settings
		for (int unsigned ph = 0; ph < 5; ph++) begin
			if (ph != 0) begin
				drain();
				case (ph)
					1: write_config(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
					2: write_config(16'd1, 32'd1, 16'd1);
					3: write_config(16'($urandom_range(1, 8)), $urandom_range(1, 200000),
						16'(8 * $urandom_range(1, 4)));
					default: write_config(16'd2, 32'd48000, 16'd24);
				endcase
			end
			// receiver holds off while the sender keeps offering
			if (ph == 2) hold_req = 1'b1;
			files = 0;
			while (bytes_parsed < (ph + 1) * ITEMS / 5) begin
				make_file();
				foreach (file_q[i])
					offer(row(file_q[i].byte_value, file_q[i].first_byte,
						file_q[i].stream_end, 1'b0, ST_OK));
				files++;
				if (files % 25 == 0) drain();
			end
		end

		byte_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (2 * SETTLE) @(posedge clk);

		$display("coverage: %0d parsed bytes, %0d verdicts, %0d register settings",
			bytes_parsed, verdicts_seen, settings_used);
		$display("verdicts: ok %0d, early %0d, not wave %0d, fmt size %0d, rates %0d, format %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3],
			status_tally[4], status_tally[5]);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
